// ===== design/i2cdt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cdt_pkg
// Shared types, codes and the identity preload for the dual target slave.
// ----------------------------------------------------------------------------
package i2cdt_pkg;

    // bus event codes
    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_ADDR  = 2'd1,
        ACT_WRITE = 2'd2,
        ACT_READ  = 2'd3
    } act_t;

    // addressed target
    typedef enum logic [1:0] {
        TGT_NONE = 2'd0,
        TGT_MEM  = 2'd1,
        TGT_LED  = 2'd2,
        TGT_WAIT = 2'd3
    } tgt_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic commit;
    } dp_cmd_t;

    localparam logic CFG_IDX_MEM = 1'b0;
    localparam logic CFG_IDX_LED = 1'b1;

    localparam logic [6:0] MEM_ADDR_RST = 7'h50;
    localparam logic [6:0] LED_ADDR_RST = 7'h60;
    localparam logic [7:0] BYTE_IDLE    = 8'hFF;

    localparam int LED_MAX   = 4;
    localparam int LED_PTR_W = 2;
    localparam int IN_W      = 16;
    localparam int OUT_W     = 40;

    localparam logic [7:0] IDENT_TABLE [128] = '{
        8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h09, 8'hD1,
        8'h01, 8'h84, 8'h3A, 8'h00, 8'h00, 8'h00, 8'h09, 8'h11, 8'h01, 8'h03,
        8'h80, 8'h00, 8'h00, 8'h78, 8'h2A, 8'h5F, 8'h9F, 8'hA9, 8'h55, 8'h50,
        8'h92, 8'h24, 8'h0D, 8'h4A, 8'h4B, 8'hA5, 8'h4A, 8'h00, 8'h61, 8'h59,
        8'hD1, 8'hC0, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01,
        8'h01, 8'h01, 8'h01, 8'h01, 8'h02, 8'h3A, 8'h80, 8'h18, 8'h71, 8'h38,
        8'h2D, 8'h40, 8'h58, 8'h2C, 8'h45, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h1E, 8'h00, 8'h00, 8'h00, 8'hFD, 8'h00, 8'h30, 8'h58, 8'h18,
        8'h51, 8'h0F, 8'h00, 8'h0A, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20,
        8'h00, 8'h00, 8'h00, 8'hFE, 8'h00, 8'h42, 8'h65, 8'h6E, 8'h51, 8'h0A,
        8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h00, 8'h00,
        8'h00, 8'hFC, 8'h00, 8'h57, 8'h31, 8'h30, 8'h30, 8'h30, 8'h30, 8'h0A,
        8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h01, 8'h2E
    };

    // preload value of one store entry; entries past the table are zero
    function automatic logic [7:0] ident_rom(input logic [7:0] idx);
        logic [7:0] val;
        val = idx[7] ? 8'h00 : IDENT_TABLE[idx[6:0]];
        return val;
    endfunction

    // byte remainder by a fixed divisor d, m = ceil(2^16 / d) is its reciprocal;
    // exact for every byte since byte times rounding error stays below 2^16
    function automatic logic [8:0] byte_mod(input logic [7:0] v, input logic [8:0] d,
                                            input logic [16:0] m);
        logic [23:0] prod;
        logic [7:0]  quot;
        logic [16:0] back;
        prod = 24'(v) * 24'(m);
        quot = prod[23:16];
        back = 17'(quot) * 17'(d);
        return 9'(17'(v) - back);
    endfunction

endpackage

// ===== design/i2cdt_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cdt_ctrl
// Item sequencer: capture, execute, and output register handshake.
// ----------------------------------------------------------------------------
module i2cdt_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output i2cdt_pkg::dp_cmd_t cmd
);
    import i2cdt_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        s_tready       = 1'b0;
        cmd.capture    = 1'b0;
        cmd.commit     = 1'b0;
        out_valid_next = out_valid_reg && !m_tready;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // result goes out only once the output register is free
                if (!out_valid_reg || m_tready)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;

endmodule

// ===== design/i2cdt_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cdt_datapath
// Target state, identity store, LED file and result register.
// ----------------------------------------------------------------------------
module i2cdt_datapath
#(
    parameter int STORE_DEPTH = 128,
    parameter int LED_COUNT   = 3
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  i2cdt_pkg::dp_cmd_t            cmd,
    input  logic [1:0]                    in_action,
    input  logic [i2cdt_pkg::IN_W-1:0]    in_data,
    input  logic                          cfg_we,
    input  logic                          cfg_addr,
    input  logic [6:0]                    cfg_wdata,
    output logic [i2cdt_pkg::OUT_W-1:0]   out_data
);
    import i2cdt_pkg::*;

    localparam int PTR_W     = $clog2(STORE_DEPTH);
    localparam int MEM_RECIP = (65536 + STORE_DEPTH - 1) / STORE_DEPTH;
    localparam int LED_RECIP = (65536 + LED_COUNT - 1) / LED_COUNT;

    logic [6:0]           mem_dev_reg;
    logic [6:0]           led_dev_reg;

    act_t                 act_reg;
    logic [7:0]           byte_reg;
    logic                 mack_reg;

    logic [PTR_W-1:0]     mem_ptr_reg;
    logic [PTR_W-1:0]     mem_ptr_next;
    logic [LED_PTR_W-1:0] led_ptr_reg;
    logic [LED_PTR_W-1:0] led_ptr_next;
    logic [7:0]           led_val_reg [LED_MAX];
    logic                 led_we;
    tgt_t                 tgt_reg;
    tgt_t                 tgt_next;
    logic                 rd_dir_reg;
    logic                 rd_dir_next;
    logic                 ptr_pend_reg;
    logic                 ptr_pend_next;
    logic                 host_own_reg;
    logic                 host_own_next;

    logic [7:0]           mem [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] mem_vld_reg;
    logic [7:0]           rd_data_reg;
    logic                 rd_vld_reg;
    logic                 mem_we;
    logic [7:0]           mem_rd;

    logic                 ack;
    logic [7:0]           tx;
    logic                 sel_now;
    logic                 sel_after;
    logic [PTR_W-1:0]     mem_ptr_inc;
    logic [LED_PTR_W-1:0] led_ptr_inc;
    logic [OUT_W-1:0]     out_data_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_dev_reg <= MEM_ADDR_RST;
            led_dev_reg <= LED_ADDR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_IDX_MEM: mem_dev_reg <= cfg_wdata;
                CFG_IDX_LED: led_dev_reg <= cfg_wdata;
                default:     mem_dev_reg <= mem_dev_reg;
            endcase
        end
    end

    // captured item
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg  <= act_t'(in_action);
            byte_reg <= in_data[7:0];
            mack_reg <= in_data[8];
        end
    end

    // identity store, read port sampled every cycle at the pointer
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_ptr_reg] <= byte_reg;
        end
        rd_data_reg <= mem[mem_ptr_reg];
    end

    // entries never written read as the preload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end
        else
        begin
            if (mem_we)
            begin
                mem_vld_reg[mem_ptr_reg] <= 1'b1;
            end
            rd_vld_reg <= mem_vld_reg[mem_ptr_reg];
        end
    end

    assign mem_rd = rd_vld_reg ? rd_data_reg : ident_rom(8'(mem_ptr_reg));

    assign mem_ptr_inc = (mem_ptr_reg == PTR_W'(STORE_DEPTH - 1)) ? '0 : mem_ptr_reg + 1'b1;
    assign led_ptr_inc = (led_ptr_reg == LED_PTR_W'(LED_COUNT - 1)) ? '0
                                                                     : led_ptr_reg + 1'b1;
    assign sel_now     = (tgt_reg == TGT_MEM) || (tgt_reg == TGT_LED);

    always_comb
    begin
        tgt_next      = tgt_reg;
        rd_dir_next   = rd_dir_reg;
        ptr_pend_next = ptr_pend_reg;
        host_own_next = host_own_reg;
        mem_ptr_next  = mem_ptr_reg;
        led_ptr_next  = led_ptr_reg;
        mem_we        = 1'b0;
        led_we        = 1'b0;
        ack           = 1'b0;
        tx            = BYTE_IDLE;
        case (act_reg)
            ACT_START:
            begin
                tgt_next      = TGT_WAIT;
                ptr_pend_next = 1'b0;
            end
            ACT_ADDR:
            begin
                if (tgt_reg == TGT_WAIT)
                begin
                    rd_dir_next   = byte_reg[0];
                    ptr_pend_next = 1'b1;
                    // memory target wins when both addresses match
                    if (byte_reg[7:1] == mem_dev_reg)
                    begin
                        tgt_next = TGT_MEM;
                        ack      = 1'b1;
                    end
                    else if (byte_reg[7:1] == led_dev_reg)
                    begin
                        tgt_next = TGT_LED;
                        ack      = 1'b1;
                    end
                    else
                    begin
                        tgt_next = TGT_NONE;
                    end
                end
            end
            ACT_WRITE:
            begin
                if (sel_now && !rd_dir_reg)
                begin
                    ack           = 1'b1;
                    ptr_pend_next = 1'b0;
                    if (tgt_reg == TGT_MEM)
                    begin
                        if (ptr_pend_reg)
                        begin
                            mem_ptr_next = PTR_W'(byte_mod(byte_reg, 9'(STORE_DEPTH),
                                                           17'(MEM_RECIP)));
                        end
                        else
                        begin
                            mem_we       = cmd.commit;
                            mem_ptr_next = mem_ptr_inc;
                        end
                    end
                    else
                    begin
                        host_own_next = 1'b1;
                        if (ptr_pend_reg)
                        begin
                            led_ptr_next = LED_PTR_W'(byte_mod(byte_reg, 9'(LED_COUNT),
                                                               17'(LED_RECIP)));
                        end
                        else
                        begin
                            led_we       = cmd.commit;
                            led_ptr_next = led_ptr_inc;
                        end
                    end
                end
            end
            ACT_READ:
            begin
                if (sel_now && rd_dir_reg && mack_reg)
                begin
                    if (tgt_reg == TGT_MEM)
                    begin
                        tx            = mem_rd;
                        host_own_next = 1'b0;
                        mem_ptr_next  = mem_ptr_inc;
                    end
                    else
                    begin
                        tx           = led_val_reg[led_ptr_reg];
                        led_ptr_next = led_ptr_inc;
                    end
                end
            end
            default:
            begin
                tgt_next = tgt_reg;
            end
        endcase
    end

    assign sel_after = (tgt_next == TGT_MEM) || (tgt_next == TGT_LED);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tgt_reg      <= TGT_NONE;
            rd_dir_reg   <= 1'b0;
            ptr_pend_reg <= 1'b0;
            host_own_reg <= 1'b0;
            mem_ptr_reg  <= '0;
            led_ptr_reg  <= '0;
            for (int i = 0; i < LED_MAX; i++)
            begin
                led_val_reg[i] <= 8'h00;
            end
        end
        else if (cmd.commit)
        begin
            tgt_reg      <= tgt_next;
            rd_dir_reg   <= rd_dir_next;
            ptr_pend_reg <= ptr_pend_next;
            host_own_reg <= host_own_next;
            mem_ptr_reg  <= mem_ptr_next;
            led_ptr_reg  <= led_ptr_next;
            if (led_we)
            begin
                led_val_reg[led_ptr_reg] <= byte_reg;
            end
        end
    end

    // result item; LED entries past LED_COUNT are never written and stay zero
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_data_reg <= {5'd0,
                             (led_we && led_ptr_reg == 2'd2) ? byte_reg : led_val_reg[2],
                             (led_we && led_ptr_reg == 2'd1) ? byte_reg : led_val_reg[1],
                             (led_we && led_ptr_reg == 2'd0) ? byte_reg : led_val_reg[0],
                             host_own_next, sel_after, tx, ack};
        end
    end

    assign out_data = out_data_reg;

endmodule

// ===== design/i2c_dual_target_register_slave_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_dual_target_register_slave_top
// Byte-level two-wire target with an identity memory and an LED value file.
// ----------------------------------------------------------------------------
// Each bus event item is captured in the idle state while the identity store
// is read at the current pointer (registered read port); the execute state
// then updates the target state and loads the result register. One item is
// in flight at a time; the result register lets the next item in while a
// result still waits, and an item finishing while the register is full waits
// in the execute state. Store entries never written since reset read as the
// preload through one valid bit per entry, so no clearing pass is needed.
module i2c_dual_target_register_slave_top
#(
    parameter int STORE_DEPTH = 128,
    parameter int LED_COUNT   = 3
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // bus_byte[7:0], master_ack[8], zero[15:9]
    input  logic [1:0]  s_tuser,   // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // drive_ack[0], transmit_byte[8:1], selected[9],
                                   // leds_host_owned[10], led_red[18:11],
                                   // led_green[26:19], led_blue[34:27], zero[39:35]
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [6:0]  cfg_wdata
);
    import i2cdt_pkg::*;

    dp_cmd_t cmd;

    i2cdt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    i2cdt_datapath
    #(
        .STORE_DEPTH (STORE_DEPTH),
        .LED_COUNT   (LED_COUNT)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_action (s_tuser),
        .in_data   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .out_data  (m_tdata)
    );

`ifndef SYNTHESIS
    // one item at a time: no accept right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted while previous item still executing");

    // an acknowledge never comes with read data
    a_ack_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> m_tdata[8:1] == BYTE_IDLE)
        else $error("acknowledge together with transmitted data");

    // read data only while a target stays addressed
    a_data_needs_sel: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[9] |-> m_tdata[8:1] == BYTE_IDLE)
        else $error("transmitted data without a selected target");

    // commit only from the execute state, never in the same cycle as a capture
    a_commit_after_capture: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> !cmd.commit)
        else $error("capture and commit in the same cycle");
`endif

endmodule
